[rtl/dfs_pkg.sv]
package dfs_pkg;

   // The delimiter register holds this many bytes.
   localparam int DELIM_BYTES = 8;
   localparam int DELIM_W     = 8 * DELIM_BYTES;
   localparam int LEN_W       = 4;
   localparam int CSR_INDEX_W = 2;

   // Depth of the command queue between the front and the back.
   localparam int FIFO_DEPTH  = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_LEN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_BYTES = 2'd1;

   // Reset values of the configuration registers (a single comma).
   localparam logic [LEN_W-1:0]   DELIM_LEN_RESET   = 4'd1;
   localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET = 64'd44;

   // Work for the back end that one input word produces.
   typedef struct packed {
      logic [LEN_W-1:0] pre_cnt;    // leading delimiter bytes to release
      logic             emit_c;     // release the input byte itself
      logic             mark;       // a delimiter just completed
      logic [7:0]       data_byte;  // the input byte
      logic [LEN_W-1:0] flush_cnt;  // held bytes flushed at end of string
      logic             fin_mark;   // close the final field
   } cmd_type;

endpackage

[rtl/dfs_front.sv]
module dfs_front import dfs_pkg::*; #(
   parameter int MAX_DELIM = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_has_byte,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last,
   // Configuration writes.
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DELIM_W-1:0]     csr_wdata,
   // Command queue side.
   input  logic                   fifo_full,
   output logic                   push,
   output cmd_type                cmd,
   output logic [DELIM_W-1:0]     delim_bytes
);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DELIM_W-1:0] delim_ff, delim_in;
   logic [LEN_W-1:0]   matched_ff, matched_in;

   logic [LEN_W-1:0]   eff_len;
   logic [LEN_W-1:0]   m_cur;
   logic [7:0]         db [DELIM_BYTES];
   logic               period_ok [DELIM_BYTES][DELIM_BYTES];
   logic [LEN_W-1:0]   j_sel;
   logic [LEN_W-1:0]   m_inc;
   logic [LEN_W-1:0]   m_after;
   logic               accept;
   logic               hit;
   logic               done_match;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = fifo_full;
   assign delim_bytes = delim_ff;

   // Effective delimiter length, clamped to the supported range.
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_DELIM)) begin
         eff_len = LEN_W'(MAX_DELIM);
      end else begin
         eff_len = len_ff;
      end
      m_cur = (matched_ff >= eff_len) ? '0 : matched_ff;
   end

   // Self-overlap table of the delimiter: period_ok[d][l] is true when the
   // l bytes starting at offset d equal the first l bytes.
   always_comb begin
      for (int i = 0; i < DELIM_BYTES; i++) begin
         db[i] = delim_ff[8*i +: 8];
      end
      for (int d = 0; d < DELIM_BYTES; d++) begin
         period_ok[d][0] = 1'b1;
         for (int l = 1; l < DELIM_BYTES; l++) begin
            if (d + l - 1 < DELIM_BYTES) begin
               period_ok[d][l] = period_ok[d][l-1] && (db[d+l-1] == db[l-1]);
            end else begin
               period_ok[d][l] = 1'b0;
            end
         end
      end
   end

   // Longest suffix of the held bytes plus the new byte that still starts a
   // delimiter. Each candidate length is checked in parallel.
   always_comb begin
      j_sel = '0;
      for (int j = 1; j < DELIM_BYTES; j++) begin
         if (LEN_W'(j) <= m_cur &&
             period_ok[3'(int'(m_cur) + 1 - j)][j-1] &&
             req_data_byte == db[j-1]) begin
            j_sel = LEN_W'(j);
         end
      end
   end

   // Classify the word and build the command for the back end.
   always_comb begin
      hit        = req_data_byte == db[m_cur[2:0]];
      m_inc      = m_cur + LEN_W'(1);
      done_match = req_has_byte && hit && (m_inc == eff_len);
      cmd        = '0;
      cmd.data_byte = req_data_byte;
      m_after    = m_cur;
      if (req_has_byte) begin
         if (hit) begin
            m_after  = done_match ? '0 : m_inc;
            cmd.mark = done_match;
         end else begin
            cmd.emit_c  = (j_sel == '0);
            cmd.pre_cnt = (j_sel == '0) ? m_cur : LEN_W'(m_inc - j_sel);
            m_after     = j_sel;
         end
      end
      if (req_last) begin
         cmd.flush_cnt = m_after;
         cmd.fin_mark  = 1'b1;
      end
      push = accept && (req_last || done_match || (req_has_byte && !hit));
   end

   // Next values of the configuration and match state.
   always_comb begin
      len_in     = len_ff;
      delim_in   = delim_ff;
      matched_in = matched_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DELIM_LEN) begin
            len_in = csr_wdata[LEN_W-1:0];
         end else if (csr_index == CSR_DELIM_BYTES) begin
            delim_in = csr_wdata;
         end
         matched_in = '0;
      end else if (accept) begin
         matched_in = req_last ? '0 : m_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= DELIM_LEN_RESET;
         delim_ff   <= DELIM_BYTES_RESET;
         matched_ff <= '0;
      end else begin
         len_ff     <= len_in;
         delim_ff   <= delim_in;
         matched_ff <= matched_in;
      end
   end

endmodule

[rtl/dfs_fifo.sv]
module dfs_fifo import dfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/dfs_back.sv]
module dfs_back import dfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Command queue side.
   input  logic               fifo_not_empty,
   input  cmd_type            fifo_data,
   output logic               pop,
   input  logic [DELIM_W-1:0] delim_bytes,
   // Result stream.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_byte_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_field_end,
   output logic               rsp_string_end
);

   typedef enum logic [1:0] {
      PH_PRE,
      PH_MID,
      PH_FLUSH,
      PH_FINAL
   } phase_type;

   cmd_type          cur_ff, cur_in;
   logic             busy_ff, busy_in;
   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             byte_valid_ff, byte_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             field_end_ff, field_end_in;
   logic             string_end_ff, string_end_in;

   logic [3:0]       cur_mask;
   logic [3:0]       new_mask;
   logic [LEN_W-1:0] phase_cnt;
   logic             last_in_phase;
   logic [2:0]       next_pick;
   logic [2:0]       first_pick;
   logic             slot_free;
   logic             fire;
   logic             cmd_done;
   logic [7:0]       held_byte;

   // Which of the four phases of a command have any results.
   function automatic logic [3:0] phase_mask(input cmd_type c);
      phase_mask = {c.fin_mark, (c.flush_cnt != '0), (c.emit_c || c.mark),
                    (c.pre_cnt != '0)};
   endfunction

   // First non-empty phase at or after start: {found, phase}.
   function automatic logic [2:0] pick_phase(input logic [3:0] mask,
                                             input logic [2:0] start);
      logic       found;
      logic [1:0] sel;
      found = 1'b0;
      sel   = '0;
      for (int p = 0; p < 4; p++) begin
         if (3'(p) >= start && mask[p] && !found) begin
            found = 1'b1;
            sel   = 2'(p);
         end
      end
      pick_phase = {found, sel};
   endfunction

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_field_end  = field_end_ff;
   assign rsp_string_end = string_end_ff;

   // Step through the current command, one result per cycle while the output slot is free.
   always_comb begin
      cur_mask   = phase_mask(cur_ff);
      new_mask   = phase_mask(fifo_data);
      first_pick = pick_phase(new_mask, 3'd0);
      next_pick  = pick_phase(cur_mask, {1'b0, phase_ff} + 3'd1);
      held_byte  = delim_bytes[8*idx_ff[2:0] +: 8];

      case (phase_ff)
         PH_PRE:   phase_cnt = cur_ff.pre_cnt;
         PH_FLUSH: phase_cnt = cur_ff.flush_cnt;
         default:  phase_cnt = LEN_W'(1);
      endcase
      last_in_phase = (LEN_W'(idx_ff + LEN_W'(1)) == phase_cnt);

      slot_free = !rsp_valid_ff || !rsp_stall;
      fire      = busy_ff && slot_free;
      cmd_done  = fire && last_in_phase && !next_pick[2];
      pop       = fifo_not_empty && (!busy_ff || cmd_done);

      cur_in   = cur_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = fifo_data;
         busy_in  = 1'b1;
         phase_in = phase_type'(first_pick[1:0]);
         idx_in   = '0;
      end else if (cmd_done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         if (last_in_phase) begin
            phase_in = phase_type'(next_pick[1:0]);
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + LEN_W'(1);
         end
      end
   end

   // Output register: loads a new result when the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !slot_free;
      byte_valid_in = byte_valid_ff;
      out_byte_in   = out_byte_ff;
      field_end_in  = field_end_ff;
      string_end_in = string_end_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         byte_valid_in = 1'b0;
         out_byte_in   = '0;
         field_end_in  = 1'b0;
         string_end_in = 1'b0;
         case (phase_ff)
            PH_PRE, PH_FLUSH: begin
               byte_valid_in = 1'b1;
               out_byte_in   = held_byte;
            end
            PH_MID: begin
               if (cur_ff.emit_c) begin
                  byte_valid_in = 1'b1;
                  out_byte_in   = cur_ff.data_byte;
               end else begin
                  field_end_in = 1'b1;
               end
            end
            PH_FINAL: begin
               field_end_in  = 1'b1;
               string_end_in = 1'b1;
            end
            default: begin
               byte_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_PRE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      byte_valid_ff <= byte_valid_in;
      out_byte_ff   <= out_byte_in;
      field_end_ff  <= field_end_in;
      string_end_ff <= string_end_in;
   end

endmodule

[rtl/delimiter_field_splitter.sv]
// Splits a byte stream into fields at each occurrence of a delimiter string.
// Input words (req_) carry one optional byte and a last flag; result words
// (rsp_) carry either one data byte of the current field or a field-end
// marker, with string_end set on the marker that closes the final field.
// The delimiter (1 to MAX_DELIM bytes) and its length are written through
// the csr_ port, which is always ready; any write drops a partial match.
// An input word is classified in the cycle it is accepted and, when it
// releases anything, queued as a command; the back end turns each command
// into 1 to 9 result words at one word per cycle while rsp_stall is low.
// The first result word of an input word passes through the command
// queue, the back end's command register and the output register before
// it appears on rsp_. A new input word is accepted every cycle while the
// four-entry command queue has room; sustained throughput is one result
// word per cycle while rsp_stall is low, set by the single output port of
// the back end. Reset restores a single comma delimiter and clears the
// queue and the output register. While the receiver stalls, the output
// word holds, the queue fills, and req_stall rises once the queue is full.
module delimiter_field_splitter import dfs_pkg::*; #(
   parameter int MAX_DELIM = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_has_byte,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_byte_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_field_end,
   output logic                   rsp_string_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DELIM_W-1:0]     csr_wdata
);

   cmd_type            push_cmd;
   cmd_type            pop_cmd;
   logic               push;
   logic               pop;
   logic               fifo_full;
   logic               fifo_not_empty;
   logic [DELIM_W-1:0] delim_bytes;

   assign csr_ready = 1'b1;

   // Front end: match tracking and classification.
   dfs_front #(
      .MAX_DELIM (MAX_DELIM)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_has_byte  (req_has_byte),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fifo_full     (fifo_full),
      .push          (push),
      .cmd           (push_cmd),
      .delim_bytes   (delim_bytes)
   );

   // Command queue between the two halves.
   dfs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .not_empty (fifo_not_empty),
      .pop_data  (pop_cmd)
   );

   // Back end: result word sequencer.
   dfs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_not_empty (fifo_not_empty),
      .fifo_data      (pop_cmd),
      .pop            (pop),
      .delim_bytes    (delim_bytes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_field_end  (rsp_field_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule

[rtl/dfs_checker.sv]
module dfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_field_end,
   input logic       rsp_string_end
);

   // A stalled result word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_valid) &&
         $stable(rsp_out_byte) && $stable(rsp_field_end) && $stable(rsp_string_end))
      else $error("result word changed while stalled");

   // The final marker is also a field end and never a data byte.
   a_string_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_field_end && !rsp_byte_valid)
      else $error("string end without field end");

   // A word is either a data byte or a marker.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_valid != rsp_field_end)
      else $error("result word is neither byte nor marker, or both");

   // Markers carry a zero byte.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("marker carries a nonzero byte");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind delimiter_field_splitter dfs_checker u_dfs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_field_end  (rsp_field_end),
   .rsp_string_end (rsp_string_end)
);
